@@ hw/rtl/fpt_pkg.sv @@
`default_nettype none

package fpt_pkg;

  // Matrix geometry: 4x4, column-major, element (row r, column c) at c*4 + r.
  localparam int unsigned MatDim    = 4;
  localparam int unsigned MatElems  = MatDim * MatDim;
  localparam int unsigned NumPlanes = 6;

  // Diagonal elements of the column-major matrix (indexes 0, 5, 10 and 15).
  localparam logic [MatElems-1:0] DiagMask = 16'h8421;

  // Field widths.
  localparam int unsigned ElemW  = 32;
  localparam int unsigned CoefW  = ElemW + 1;
  localparam int unsigned FracW  = 16;
  localparam int unsigned ProdW  = CoefW + ElemW;
  localparam int unsigned SumW   = ProdW + 2;

  // 1.0 in Q16.16.
  localparam logic signed [ElemW-1:0] OneQ16 = 32'sh0001_0000;

  // Commands carried by an input transaction.
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_LATCH = 2'd1,
    CMD_TEST  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  // Plane selector codes.
  localparam logic [2:0] PlaneRight  = 3'd0;
  localparam logic [2:0] PlaneLeft   = 3'd1;
  localparam logic [2:0] PlaneBottom = 3'd2;
  localparam logic [2:0] PlaneTop    = 3'd3;
  localparam logic [2:0] PlaneBack   = 3'd4;
  localparam logic [2:0] PlaneFront  = 3'd5;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [CoefW-1:0] coef_t;

  // One plane equation a*x + b*y + c*z + d, Q17.16 coefficients.
  typedef struct packed {
    coef_t a;
    coef_t b;
    coef_t c;
    coef_t d;
  } plane_t;

  // Write controls from the input decoder to the plane store.
  typedef struct packed {
    logic load;
    logic latch;
  } store_ctl_t;

  // Matrix row that a plane is built from (row 3 is always the other term).
  function automatic logic [1:0] plane_row(input logic [2:0] sel);
    logic [1:0] row;
    unique case (sel)
      PlaneRight, PlaneLeft: row = 2'd0;
      PlaneBottom, PlaneTop: row = 2'd1;
      default:               row = 2'd2;
    endcase
    return row;
  endfunction

  // True where the plane is row 3 plus the row, false where it is a difference.
  function automatic logic plane_adds(input logic [2:0] sel);
    logic add;
    unique case (sel)
      PlaneLeft, PlaneBottom, PlaneFront: add = 1'b1;
      default:                            add = 1'b0;
    endcase
    return add;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fpt_store.sv @@
`default_nettype none

module fpt_store (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire fpt_pkg::store_ctl_t  ctl_i,
  input  wire logic [3:0]           elem_index_i,
  input  wire fpt_pkg::elem_t       elem_value_i,
  input  wire logic [2:0]           plane_sel_i,
  output fpt_pkg::plane_t           plane_o,
  output logic                      plane_ok_o
);
  import fpt_pkg::*;

  elem_t  matrix_q [MatElems];
  plane_t planes_q [NumPlanes];
  plane_t planes_d [NumPlanes];

  // Plane extraction from the current matrix: row 3 plus or minus another row.
  always_comb begin
    for (int s = 0; s < NumPlanes; s++) begin
      coef_t w [MatDim];
      coef_t e [MatDim];
      coef_t r [MatDim];
      for (int c = 0; c < MatDim; c++) begin
        w[c] = CoefW'(matrix_q[c * MatDim + 3]);
        e[c] = CoefW'(matrix_q[c * MatDim + int'(plane_row(3'(s)))]);
        r[c] = plane_adds(3'(s)) ? w[c] + e[c] : w[c] - e[c];
      end
      planes_d[s].a = r[0];
      planes_d[s].b = r[1];
      planes_d[s].c = r[2];
      planes_d[s].d = r[3];
    end
  end

  // Matrix element writes; reset loads the identity matrix.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MatElems; i++) begin
        matrix_q[i] <= DiagMask[i] ? OneQ16 : '0;
      end
    end else if (ctl_i.load) begin
      matrix_q[elem_index_i] <= elem_value_i;
    end
  end

  // Plane latch; all planes clear at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumPlanes; s++) begin
        planes_q[s] <= '0;
      end
    end else if (ctl_i.latch) begin
      for (int s = 0; s < NumPlanes; s++) begin
        planes_q[s] <= planes_d[s];
      end
    end
  end

  // Selected plane for a test; codes past the last plane read as zero.
  always_comb begin
    plane_ok_o = (plane_sel_i < 3'(NumPlanes));
    plane_o    = '0;
    for (int s = 0; s < NumPlanes; s++) begin
      if (plane_sel_i == 3'(s)) begin
        plane_o = planes_q[s];
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/fpt_dot.sv @@
`default_nettype none

module fpt_dot (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire fpt_pkg::plane_t  plane_i,
  input  wire logic             plane_ok_i,
  input  wire fpt_pkg::elem_t   point_x_i,
  input  wire fpt_pkg::elem_t   point_y_i,
  input  wire fpt_pkg::elem_t   point_z_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  inside_res_o
);
  import fpt_pkg::*;

  // Stage valids and the free signals that let each stage move forward.
  logic v1_q, v2_q, v3_q, v4_q;
  logic free1, free2, free3, free4;

  // Operand stage.
  plane_t pl1_q;
  elem_t  x1_q, y1_q, z1_q;
  logic   ok1_q;

  // Product stage.
  logic signed [ProdW-1:0] p0_q, p1_q, p2_q;
  logic signed [ProdW-1:0] p0_d, p1_d, p2_d;
  coef_t                   d2_q;
  logic                    ok2_q;

  // Partial sum stage.
  logic signed [SumW-1:0] sa_q, sb_q, sa_d, sb_d;
  logic                   ok3_q;

  // Final sum and result register.
  logic signed [SumW-1:0] sum_d;
  logic                   res_q;

  assign free4 = !v4_q || out_ready_i;
  assign free3 = !v3_q || free4;
  assign free2 = !v2_q || free3;
  assign free1 = !v1_q || free2;
  assign in_ready_o = free1;

  // Exact 33 by 32 bit products.
  assign p0_d = ProdW'($signed(pl1_q.a)) * ProdW'($signed(x1_q));
  assign p1_d = ProdW'($signed(pl1_q.b)) * ProdW'($signed(y1_q));
  assign p2_d = ProdW'($signed(pl1_q.c)) * ProdW'($signed(z1_q));

  // Offset scaled from Q.16 to Q.32, then the two partial sums.
  assign sa_d = SumW'(p0_q) + SumW'(p1_q);
  assign sb_d = SumW'(p2_q) + {{(SumW - CoefW - FracW){d2_q[CoefW-1]}}, d2_q, FracW'(0)};
  assign sum_d = sa_q + sb_q;

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (free1) v1_q <= in_valid_i;
      if (free2) v2_q <= v1_q;
      if (free3) v3_q <= v2_q;
      if (free4) v4_q <= v3_q;
    end
  end

  // Datapath registers move with their stage.
  always_ff @(posedge clk_i) begin
    if (free1) begin
      pl1_q <= plane_i;
      ok1_q <= plane_ok_i;
      x1_q  <= point_x_i;
      y1_q  <= point_y_i;
      z1_q  <= point_z_i;
    end
    if (free2) begin
      p0_q  <= p0_d;
      p1_q  <= p1_d;
      p2_q  <= p2_d;
      d2_q  <= pl1_q.d;
      ok2_q <= ok1_q;
    end
    if (free3) begin
      sa_q  <= sa_d;
      sb_q  <= sb_d;
      ok3_q <= ok2_q;
    end
    if (free4) begin
      res_q <= ok3_q && !sum_d[SumW-1];
    end
  end

  assign out_valid_o  = v4_q;
  assign inside_res_o = res_q;

endmodule

`default_nettype wire

@@ hw/rtl/frustum_plane_point_test.sv @@
// Frustum plane point test.
// One input channel (in_valid_i / in_ready_o handshake) carries commands:
// a load writes one element of the column-major Q16.16 matrix, a latch
// rebuilds the six frustum planes from the current matrix, and a test
// checks a Q16.16 point against one selected plane. Loads and latches take
// effect at the edge where their transaction is accepted and give no result.
// Each test gives one result transaction on the output channel
// (out_valid_o / out_ready_i) with inside_res_o high when the plane sum is
// non-negative; selector codes past the front plane report zero.
// A test passes four registers (operands, products, partial sums, result),
// and its result stays in the result register until the receiver takes
// it; one transaction is taken per cycle while in_ready_o is high. The
// four-stage datapath holds one test per stage.
// When the receiver stalls, stages fill up behind the result register and
// in_ready_o drops only once every stage holds a test.
// Reset restores the identity matrix, clears all planes and empties the
// pipeline.
`default_nettype none

module frustum_plane_point_test (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         cmd_i,
  input  wire logic [3:0]         elem_index_i,
  input  wire logic signed [31:0] elem_value_i,
  input  wire logic [2:0]         plane_sel_i,
  input  wire logic signed [31:0] point_x_i,
  input  wire logic signed [31:0] point_y_i,
  input  wire logic signed [31:0] point_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    inside_res_o
);
  import fpt_pkg::*;

  cmd_e       cmd;
  logic       accept;
  store_ctl_t ctl;
  logic       test_valid;
  plane_t     plane;
  logic       plane_ok;

  // Command decode for an accepted transaction.
  assign cmd        = cmd_e'(cmd_i);
  assign accept     = in_valid_i && in_ready_o;
  assign ctl.load   = accept && (cmd == CMD_LOAD);
  assign ctl.latch  = accept && (cmd == CMD_LATCH);
  assign test_valid = in_valid_i && (cmd == CMD_TEST);

  fpt_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .elem_index_i (elem_index_i),
    .elem_value_i (elem_value_i),
    .plane_sel_i  (plane_sel_i),
    .plane_o      (plane),
    .plane_ok_o   (plane_ok)
  );

  fpt_dot u_dot (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (test_valid),
    .in_ready_o   (in_ready_o),
    .plane_i      (plane),
    .plane_ok_i   (plane_ok),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .inside_res_o (inside_res_o)
  );

endmodule

`default_nettype wire

@@ bench/tb_frustum_plane_point_test.sv @@
`timescale 1ns / 1ps

module tb_frustum_plane_point_test;
  import fpt_pkg::*;

  localparam int RandomItems = 1725;
  localparam elem_t QMax = 32'sh7FFF_FFFF;
  localparam elem_t QMin = 32'sh8000_0000;

  // One input transaction, with an optional hand-typed expectation for tests.
  typedef struct packed {
    cmd_e       cmd;
    logic [3:0] idx;
    elem_t      val;
    logic [2:0] sel;
    elem_t      x;
    elem_t      y;
    elem_t      z;
    logic       known;
    logic       res;
  } frustum_cmd_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         in_valid = 1'b0;
  logic         out_ready = 1'b0;
  frustum_cmd_t cur_item = '0;
  logic         in_ready_o;
  logic         out_valid_o;
  logic         inside_res_o;

  // Predicted block state.
  elem_t matrix_q16 [MatElems];
  coef_t plane_q17 [NumPlanes * 4];

  logic in_fire = 1'b0;
  logic inside_expected [$];
  int   errors = 0;
  int   burst_left = 0;

  frustum_plane_point_test uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cur_item.cmd),
    .elem_index_i (cur_item.idx),
    .elem_value_i (cur_item.val),
    .plane_sel_i  (cur_item.sel),
    .point_x_i    (cur_item.x),
    .point_y_i    (cur_item.y),
    .point_z_i    (cur_item.z),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .inside_res_o (inside_res_o)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Applies one accepted transaction to the predicted state and reports the test outcome.
  function automatic void frustum_step(input frustum_cmd_t c, output logic produces,
                                       output logic in_plane);
    logic signed [79:0] ca, cb, cc, cd, px, py, pz, acc;
    elem_t w, e;
    int   row;
    logic adds;
    produces = 1'b0;
    in_plane = 1'b0;
    case (c.cmd)
      CMD_LOAD: matrix_q16[c.idx] = c.val;
      CMD_LATCH: begin
        for (int s = 0; s < NumPlanes; s++) begin
          row = 0;
          adds = 1'b0;
          case (3'(s))
            PlaneRight:  begin row = 0; adds = 1'b0; end
            PlaneLeft:   begin row = 0; adds = 1'b1; end
            PlaneBottom: begin row = 1; adds = 1'b1; end
            PlaneTop:    begin row = 1; adds = 1'b0; end
            PlaneBack:   begin row = 2; adds = 1'b0; end
            default:     begin row = 2; adds = 1'b1; end
          endcase
          for (int col = 0; col < 4; col++) begin
            w = matrix_q16[col * 4 + 3];
            e = matrix_q16[col * 4 + row];
            plane_q17[s * 4 + col] = adds ? {w[31], w} + {e[31], e}
                                          : {w[31], w} - {e[31], e};
          end
        end
      end
      CMD_TEST: begin
        produces = 1'b1;
        if (c.sel <= PlaneFront) begin
          ca = plane_q17[c.sel * 4 + 0];
          cb = plane_q17[c.sel * 4 + 1];
          cc = plane_q17[c.sel * 4 + 2];
          cd = plane_q17[c.sel * 4 + 3];
          px = c.x;
          py = c.y;
          pz = c.z;
          // Exact sum in Q.32: the offset is scaled up by 16 fraction bits.
          acc = (cd <<< 16) + ca * px + cb * py + cc * pz;
          in_plane = ~acc[79];
        end
      end
      default: ;
    endcase
  endfunction

  // Random Q16.16 value that favors extremes and small magnitudes.
  function automatic elem_t pick_q16();
    elem_t v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 5))
          0: v = QMax;
          1: v = QMin;
          2: v = '0;
          3: v = '1;
          4: v = OneQ16;
          default: v = -OneQ16;
        endcase
      end
      1, 2, 3: begin
        v = elem_t'($urandom_range(0, 32'h0003_0000));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = elem_t'($urandom);
    endcase
    return v;
  endfunction

  function automatic frustum_cmd_t row(input cmd_e cmd, input logic [3:0] idx, input elem_t val,
                                       input logic [2:0] sel, input elem_t x, input elem_t y,
                                       input elem_t z, input logic known, input logic res);
    frustum_cmd_t r;
    r = '{cmd: cmd, idx: idx, val: val, sel: sel, x: x, y: y, z: z, known: known, res: res};
    return r;
  endfunction

  // Offers one transaction, in bursts separated by random gaps; returns once accepted.
  task automatic offer(input frustum_cmd_t c);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    cur_item <= c;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_fire);
  endtask

  // Both channels are sampled mid-cycle, where inputs and outputs are settled.
  always @(negedge clk_i) begin
    logic produces, in_plane, want;
    in_fire = rst_ni && in_valid && in_ready_o;
    if (in_fire) begin
      frustum_step(cur_item, produces, in_plane);
      if (produces) inside_expected.push_back(cur_item.known ? cur_item.res : in_plane);
    end
    if (rst_ni && out_valid_o && out_ready) begin
      if (inside_expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transaction, inside_res %0b", $time, inside_res_o);
      end else begin
        want = inside_expected.pop_front();
        if (inside_res_o !== want) begin
          errors++;
          $display("%0t: inside_res mismatch: expected %0b, actual %0b",
                   $time, want, inside_res_o);
        end
      end
    end
  end

  // Receiver: stall patterns of random length, and one long hold-off.
  initial begin : receiver
    int mode, span;
    int unsigned cycles;
    logic held;
    cycles = 0;
    held = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && cycles > 300) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (150) @(posedge clk_i);
        cycles += 150;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 64);
      for (int phase = 0; phase < span; phase++) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (phase % 4 == 0);
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk_i);
        cycles++;
      end
    end
  end

  // Stimulus: directed table first, then random commands.
  initial begin : stimulus
    frustum_cmd_t directed [$];
    frustum_cmd_t item;
    int r;
    for (int i = 0; i < MatElems; i++) matrix_q16[i] = (i % 5 == 0) ? OneQ16 : '0;
    for (int i = 0; i < NumPlanes * 4; i++) plane_q17[i] = '0;

    // Planes are all zero after reset, so every sum is zero.
    directed.push_back(row(CMD_TEST, 4'd9, QMin, PlaneRight, QMax, QMin, QMax, 1'b1, 1'b1));
    // Selector codes past the front plane always report outside.
    directed.push_back(row(CMD_TEST, 4'd0, 32'sd0, 3'd6, 32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0));
    directed.push_back(row(CMD_TEST, 4'd15, '1, 3'd7, '1, '1, '1, 1'b1, 1'b0));
    // An unused command code must leave the matrix alone.
    directed.push_back(row(CMD_NOP, 4'd15, QMin, 3'd7, QMin, QMin, QMin, 1'b0, 1'b0));
    directed.push_back(row(CMD_LATCH, 4'd0, 32'sd0, 3'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0));
    // Identity planes: right is 1 - x, left 1 + x, and so on.
    directed.push_back(row(CMD_TEST, 4'd0, 32'sd0, PlaneRight, 32'sd0, QMax, QMin, 1'b1, 1'b1));
    directed.push_back(row(CMD_TEST, 4'd0, 32'sd0, PlaneRight, QMax, 32'sd0, 32'sd0, 1'b1, 1'b0));
    directed.push_back(row(CMD_TEST, 4'd0, 32'sd0, PlaneRight, OneQ16, 32'sd0, 32'sd0,
                           1'b1, 1'b1));
    directed.push_back(row(CMD_TEST, 4'd0, 32'sd0, PlaneRight, OneQ16 + 1, 32'sd0, 32'sd0,
                           1'b1, 1'b0));
    directed.push_back(row(CMD_TEST, 4'd0, 32'sd0, PlaneLeft, QMin, 32'sd0, 32'sd0, 1'b1, 1'b0));
    directed.push_back(row(CMD_TEST, 4'd0, 32'sd0, PlaneBottom, 32'sd0, QMin, 32'sd0,
                           1'b1, 1'b0));
    directed.push_back(row(CMD_TEST, 4'd0, 32'sd0, PlaneTop, 32'sd0, QMin, 32'sd0, 1'b1, 1'b1));
    directed.push_back(row(CMD_TEST, 4'd0, 32'sd0, PlaneBack, 32'sd0, 32'sd0, QMax, 1'b1, 1'b0));
    directed.push_back(row(CMD_TEST, 4'd0, 32'sd0, PlaneFront, 32'sd0, 32'sd0, QMax, 1'b1, 1'b1));
    // Extreme matrix elements, then the predictor takes over.
    directed.push_back(row(CMD_LOAD, 4'd0, QMax, 3'd7, '1, '1, '1, 1'b0, 1'b0));
    directed.push_back(row(CMD_LOAD, 4'd15, QMin, 3'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0));
    directed.push_back(row(CMD_LOAD, 4'd3, '1, 3'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0));
    directed.push_back(row(CMD_LOAD, 4'd10, QMax, 3'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0));
    directed.push_back(row(CMD_LOAD, 4'd5, QMin, 3'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0));
    directed.push_back(row(CMD_LATCH, 4'd15, QMax, 3'd7, QMax, QMax, QMax, 1'b0, 1'b0));
    directed.push_back(row(CMD_TEST, 4'd0, 32'sd0, PlaneRight, QMax, QMax, QMax, 1'b0, 1'b0));
    directed.push_back(row(CMD_TEST, 4'd0, 32'sd0, PlaneLeft, QMin, QMin, QMin, 1'b0, 1'b0));
    directed.push_back(row(CMD_TEST, 4'd0, 32'sd0, PlaneBottom, QMax, QMin, 32'sd0,
                           1'b0, 1'b0));
    directed.push_back(row(CMD_TEST, 4'd0, 32'sd0, PlaneTop, QMin, QMax, '1, 1'b0, 1'b0));
    directed.push_back(row(CMD_TEST, 4'd0, 32'sd0, PlaneBack, '1, OneQ16, QMin, 1'b0, 1'b0));
    directed.push_back(row(CMD_TEST, 4'd0, 32'sd0, PlaneFront, QMin, QMax, QMax, 1'b0, 1'b0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) offer(directed[i]);

    // Random commands: loads and latches build matrices, tests probe them.
    repeat (RandomItems) begin
      r = $urandom_range(0, 99);
      if (r < 40) item.cmd = CMD_LOAD;
      else if (r < 50) item.cmd = CMD_LATCH;
      else if (r < 95) item.cmd = CMD_TEST;
      else item.cmd = CMD_NOP;
      item.idx = 4'($urandom);
      item.val = pick_q16();
      item.sel = ($urandom_range(0, 6) != 0) ? 3'($urandom_range(0, 5))
                                             : 3'($urandom_range(6, 7));
      item.x = pick_q16();
      item.y = pick_q16();
      item.z = pick_q16();
      item.known = 1'b0;
      item.res = 1'b0;
      offer(item);
    end
    in_valid <= 1'b0;

    // Drain outstanding tests, then watch for stray result transactions.
    while (inside_expected.size() != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
